>>> src/rhbq_pkg.sv
`timescale 1ns / 1ps

package rhbq_pkg;

	// diff band thresholds and band code width
	localparam int BAND_W = 3;
	localparam logic [7:0] BAND1_LOW = 8'd6;
	localparam logic [7:0] BAND2_LOW = 8'd20;
	localparam logic [7:0] BAND3_LOW = 8'd60;
	localparam logic [7:0] BAND4_LOW = 8'd110;

	typedef enum logic [BAND_W-1:0] {
		BAND_GRAY  = 3'd0,
		BAND_LOW   = 3'd1,
		BAND_MID   = 3'd2,
		BAND_HIGH  = 3'd3,
		BAND_VIVID = 3'd4
	} band_t;

	// reciprocal scaling for the hue divider
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 18;
	localparam int NUMER_W     = 19;

	// values that travel beside the hue divider
	typedef struct packed {
		logic [7:0] diff;
		logic [7:0] sum;
		band_t      band;
	} side_t;

	function automatic band_t band_of(input logic [7:0] d);
		band_t b;
		if (d >= BAND4_LOW) begin
			b = BAND_VIVID;
		end else if (d >= BAND3_LOW) begin
			b = BAND_HIGH;
		end else if (d >= BAND2_LOW) begin
			b = BAND_MID;
		end else if (d >= BAND1_LOW) begin
			b = BAND_LOW;
		end else begin
			b = BAND_GRAY;
		end
		return b;
	endfunction

	// (hue levels - 1) * sum levels
	function automatic logic [5:0] hue_weight(input band_t b);
		logic [5:0] w;
		case (b)
			BAND_GRAY:  w = 6'd0;
			BAND_LOW:   w = 6'd28;
			BAND_MID:   w = 6'd44;
			BAND_HIGH:  w = 6'd44;
			BAND_VIVID: w = 6'd46;
			default:    w = 6'd0;
		endcase
		return w;
	endfunction

	// sum levels - 1
	function automatic logic [2:0] sum_weight(input band_t b);
		logic [2:0] w;
		case (b)
			BAND_GRAY:  w = 3'd7;
			BAND_LOW:   w = 3'd3;
			BAND_MID:   w = 3'd3;
			BAND_HIGH:  w = 3'd3;
			BAND_VIVID: w = 3'd1;
			default:    w = 3'd0;
		endcase
		return w;
	endfunction

	// first bin of each band
	function automatic logic [7:0] band_first(input band_t b);
		logic [7:0] f;
		case (b)
			BAND_GRAY:  f = 8'd0;
			BAND_LOW:   f = 8'd8;
			BAND_MID:   f = 8'd40;
			BAND_HIGH:  f = 8'd88;
			BAND_VIVID: f = 8'd136;
			default:    f = 8'd0;
		endcase
		return f;
	endfunction

endpackage

>>> src/rgb_to_hmmd_bin_quantizer_top.sv
`timescale 1ns / 1ps

// Converts one RGB pixel per transfer into HMMD hue, diff and sum bytes and a
// color-structure bin index in 0..183. The pipeline takes one pixel every
// cycle when the output side does not stall; the hue division by 6*diff is
// done with a reciprocal table and one correction step over four stages, and
// the bin scaling by 1/255 is a reciprocal multiply. Back-pressure stalls only
// the stages that hold data, so bubbles are filled while a result waits.
module rgb_to_hmmd_bin_quantizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // hue_byte, diff_byte, sum_byte, bin_index
);

	typedef enum logic [1:0] {
		SEXT_RED_MIN   = 2'd0,
		SEXT_GREEN_MIN = 2'd1,
		SEXT_BLUE_MIN  = 2'd2
	} sext_t;

	logic [7:0] red, green, blue;
	assign red   = s_axis_tdata[7:0];
	assign green = s_axis_tdata[15:8];
	assign blue  = s_axis_tdata[23:16];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic div_in_ready, div_out_valid;

	// stage ready chain
	assign rdy_s5        = !v_s5 || m_axis_tready;
	assign rdy_s4        = !v_s4 || rdy_s5;
	assign rdy_s3        = !v_s3 || div_in_ready;
	assign rdy_s2        = !v_s2 || rdy_s3;
	assign rdy_s1        = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= div_out_valid;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// s1: max, min and sextant
	logic [7:0]        mx, mn;
	sext_t             sext;
	logic signed [8:0] f;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red == mn) begin
			sext = SEXT_RED_MIN;
			f    = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green == mn) begin
			sext = SEXT_GREEN_MIN;
			f    = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sext = SEXT_BLUE_MIN;
			f    = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	logic [7:0]        mx_s1, mn_s1;
	sext_t             sext_s1;
	logic signed [8:0] f_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			mx_s1   <= mx;
			mn_s1   <= mn;
			sext_s1 <= sext;
			f_s1    <= f;
		end
	end

	// s2: diff, rounded sum and hue numerator k*d - f
	logic [7:0]         d;
	logic [8:0]         mm_sum;
	logic [10:0]        kd;
	logic signed [11:0] un_w;

	assign d      = mx_s1 - mn_s1;
	assign mm_sum = 9'(mx_s1) + 9'(mn_s1) + 9'd1;

	always_comb begin
		case (sext_s1)
			SEXT_RED_MIN:   kd = 11'({d, 1'b0}) + 11'(d);
			SEXT_GREEN_MIN: kd = 11'({d, 2'b00}) + 11'(d);
			SEXT_BLUE_MIN:  kd = 11'(d);
			default:        kd = 11'(d);
		endcase
	end

	assign un_w = $signed({1'b0, kd}) - $signed({{3{f_s1[8]}}, f_s1});

	logic [7:0]  d_s2, sum_s2;
	logic [10:0] un_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			d_s2   <= d;
			sum_s2 <= mm_sum[8:1];
			un_s2  <= un_w[10:0];
		end
	end

	// s3: divider numerator 255*un + 3*d, and band
	logic [rhbq_pkg::NUMER_W-1:0] numer;
	assign numer = {un_s2, 8'b0} - rhbq_pkg::NUMER_W'(un_s2)
		+ rhbq_pkg::NUMER_W'({d_s2, 1'b0}) + rhbq_pkg::NUMER_W'(d_s2);

	logic [rhbq_pkg::NUMER_W-1:0] numer_s3;
	logic [7:0]                   d_s3;
	rhbq_pkg::side_t              side_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			numer_s3      <= numer;
			d_s3          <= d_s2;
			side_s3.diff  <= d_s2;
			side_s3.sum   <= sum_s2;
			side_s3.band  <= rhbq_pkg::band_of(d_s2);
		end
	end

	// hue division pipeline
	logic [7:0]      hue_div;
	rhbq_pkg::side_t side_div;

	rhbq_hue_div u_hue_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_in_ready),
		.numer     (numer_s3),
		.diff      (d_s3),
		.side_in   (side_s3),
		.out_valid (div_out_valid),
		.out_ready (rdy_s4),
		.hue       (hue_div),
		.side_out  (side_div)
	);

	// s4: weighted hue and sum term
	logic [13:0] term;
	assign term = 14'(hue_div) * 14'(rhbq_pkg::hue_weight(side_div.band))
		+ 14'(side_div.sum) * 14'(rhbq_pkg::sum_weight(side_div.band));

	logic [13:0] term_s4;
	logic [7:0]  first_s4, hue_s4, diff_s4, sum_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && div_out_valid) begin
			term_s4  <= term;
			first_s4 <= rhbq_pkg::band_first(side_div.band);
			hue_s4   <= hue_div;
			diff_s4  <= side_div.diff;
			sum_s4   <= side_div.sum;
		end
	end

	// s5: term / 255 as multiply by 0x8081 and shift by 23
	logic [29:0] scaled;
	assign scaled = 30'(term_s4) * 30'h8081;

	logic [7:0] hue_s5, diff_s5, sum_s5, bin_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			hue_s5  <= hue_s4;
			diff_s5 <= diff_s4;
			sum_s5  <= sum_s4;
			bin_s5  <= first_s4 + 8'(scaled[30-1:23]);
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {bin_s5, sum_s5, diff_s5, hue_s5};

endmodule

>>> src/rhbq_hue_div.sv
`timescale 1ns / 1ps

module rhbq_hue_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rhbq_pkg::NUMER_W-1:0]  numer,
	input  logic [7:0]                    diff,
	input  rhbq_pkg::side_t               side_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    hue,
	output rhbq_pkg::side_t               side_out
);

	// reciprocal table of 6*d, indexed by d
	logic [rhbq_pkg::RECIP_W-1:0] recip_tbl [256];

	for (genvar i = 0; i < 256; i++) begin : g_recip
		localparam int RV = (1 << rhbq_pkg::RECIP_SHIFT) / (6 * ((i == 0) ? 1 : i));
		assign recip_tbl[i] = rhbq_pkg::RECIP_W'(RV);
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [rhbq_pkg::NUMER_W-1:0] numer_s1, numer_s2, numer_s3;
	logic [rhbq_pkg::RECIP_W-1:0] recip_s1;
	logic [10:0]                  d6_s1, d6_s2, d6_s3;
	logic                         zero_s1, zero_s2, zero_s3;
	rhbq_pkg::side_t              side_s1, side_s2, side_s3, side_s4;
	logic [7:0]                   q_s2, q_s3;
	logic [rhbq_pkg::NUMER_W-1:0] qd_s3;
	logic [7:0]                   hue_s4;

	logic [rhbq_pkg::NUMER_W+rhbq_pkg::RECIP_W-1:0] prod;
	logic [rhbq_pkg::NUMER_W-1:0]                   rem;
	logic                                           inc;

	// stage ready chain
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// s1: reciprocal lookup and 6*d
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			numer_s1 <= numer;
			recip_s1 <= recip_tbl[diff];
			d6_s1    <= 11'({diff, 2'b00}) + 11'({diff, 1'b0});
			zero_s1  <= (diff == 8'd0);
			side_s1  <= side_in;
		end
	end

	// s2: quotient estimate, at most one below the true value
	assign prod = (rhbq_pkg::NUMER_W+rhbq_pkg::RECIP_W)'(numer_s1)
		* (rhbq_pkg::NUMER_W+rhbq_pkg::RECIP_W)'(recip_s1);

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			q_s2     <= prod[rhbq_pkg::RECIP_SHIFT +: 8];
			numer_s2 <= numer_s1;
			d6_s2    <= d6_s1;
			zero_s2  <= zero_s1;
			side_s2  <= side_s1;
		end
	end

	// s3: estimate times divisor
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			qd_s3    <= rhbq_pkg::NUMER_W'(q_s2) * rhbq_pkg::NUMER_W'(d6_s2);
			q_s3     <= q_s2;
			numer_s3 <= numer_s2;
			d6_s3    <= d6_s2;
			zero_s3  <= zero_s2;
			side_s3  <= side_s2;
		end
	end

	// s4: remainder correction, gray pixels force hue to zero
	assign rem = numer_s3 - qd_s3;
	assign inc = (rem >= rhbq_pkg::NUMER_W'(d6_s3));

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			hue_s4  <= zero_s3 ? 8'd0 : 8'(9'(q_s3) + 9'(inc));
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign hue       = hue_s4;
	assign side_out  = side_s4;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int CLK_HALF    = 10;
	localparam int RESET_TICKS = 12;
	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_TICKS  = 40;
	localparam int MAX_REPORTS = 10;
	localparam int LONG_HOLD   = 300;

	// one HMMD result, fields in tdata order from the high byte down
	typedef struct packed {
		logic [7:0] bin_index;
		logic [7:0] sum_byte;
		logic [7:0] diff_byte;
		logic [7:0] hue_byte;
	} hmmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_valid = 1'b0;
	logic [23:0] s_data = 24'd0;
	logic        m_ready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [31:0] m_axis_tdata;

	hmmd_t expected_hmmd[$];
	int    mismatches = 0;
	int    pixels_sent = 0;
	int    results_checked = 0;
	bit    src_idle = 1'b1;
	bit    sink_idle = 1'b1;
	int    hold_ticks = 0;
	int    quiet_ticks = 0;

	rgb_to_hmmd_bin_quantizer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// hmmd conversion and bin quantization of one pixel
	function automatic hmmd_t quantize_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int ri, gi, bi, mx, mn, d, k, f, num, hue, sum, qh, qs, first;
		hmmd_t res;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		mx = ri;
		if (gi > mx) mx = gi;
		if (bi > mx) mx = bi;
		mn = ri;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		d = mx - mn;
		// sextant hue, red tested as minimum first, then green
		if (d == 0) begin
			hue = 0;
		end else begin
			if (ri == mn) begin
				k = 3;
				f = gi - bi;
			end else if (gi == mn) begin
				k = 5;
				f = bi - ri;
			end else begin
				k = 1;
				f = ri - gi;
			end
			num = k * d - f;
			if (num < 0) num = 0;
			hue = (510 * num + 6 * d) / (12 * d);
		end
		sum = (mx + mn + 1) >> 1;
		// diff band picks hue levels, sum levels and first bin
		if (d >= 110) begin
			qh = 24; qs = 2; first = 136;
		end else if (d >= 60) begin
			qh = 12; qs = 4; first = 88;
		end else if (d >= 20) begin
			qh = 12; qs = 4; first = 40;
		end else if (d >= 6) begin
			qh = 8; qs = 4; first = 8;
		end else begin
			qh = 1; qs = 8; first = 0;
		end
		res.hue_byte  = hue[7:0];
		res.diff_byte = d[7:0];
		res.sum_byte  = sum[7:0];
		res.bin_index = 8'(first + (hue * (qh - 1) * qs + sum * (qs - 1)) / 255);
		return res;
	endfunction

	function automatic void note_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on result %0d: %s expected %0d, got %0d",
					results_checked, field, want, got);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		hmmd_t want;
		hmmd_t got;
		if (arst_n && m_axis_tvalid && m_ready) begin
			got = m_axis_tdata;
			if (expected_hmmd.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result %h with nothing pending", m_axis_tdata);
			end else begin
				want = expected_hmmd.pop_front();
				note_field("hue_byte", want.hue_byte, got.hue_byte);
				note_field("diff_byte", want.diff_byte, got.diff_byte);
				note_field("sum_byte", want.sum_byte, got.sum_byte);
				note_field("bin_index", want.bin_index, got.bin_index);
			end
			results_checked++;
		end
	end

	// output side: random stalls per result, long hold on request
	initial begin
		int wait_ticks;
		while (!arst_n) @(posedge clk);
		forever begin
			wait_ticks = sink_idle ? $urandom_range(0, 8) : 0;
			wait_ticks += hold_ticks;
			hold_ticks = 0;
			if (wait_ticks > 0) begin
				m_ready <= 1'b0;
				repeat (wait_ticks) @(posedge clk);
			end
			m_ready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_ready) && hold_ticks == 0);
		end
	end

	// watchdog on cycles with no transfer on either side
	initial begin
		forever begin
			@(posedge clk);
			if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
				quiet_ticks = 0;
			else
				quiet_ticks++;
			if (quiet_ticks >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// offer one pixel, after a random gap if src_idle is set, and wait for its transfer
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = src_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= {b, g, r};
		do @(posedge clk); while (!(s_valid && s_axis_tready));
		expected_hmmd.push_back(quantize_pixel(r, g, b));
		pixels_sent++;
	endtask

	task automatic wait_drained();
		s_valid <= 1'b0;
		while (expected_hmmd.size() != 0) @(posedge clk);
	endtask

	// random pixel mixing narrow and wide diffs and ties so every band is reached
	task automatic send_random_pixel();
		logic [7:0] base;
		logic [7:0] spread;
		case ($urandom_range(0, 3))
			0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			1: begin
				base = 8'($urandom);
				spread = 8'($urandom_range(0, 24));
				send_pixel(base, 8'(base + $urandom_range(0, spread)),
					8'(base - $urandom_range(0, spread)));
			end
			2: begin
				base = 8'($urandom_range(0, 140));
				spread = 8'($urandom_range(50, 115));
				send_pixel(8'(base + $urandom_range(0, spread)), base, 8'(base + spread));
			end
			default: begin
				base = 8'($urandom);
				case ($urandom_range(0, 2))
					0: send_pixel(base, base, 8'($urandom));
					1: send_pixel(8'($urandom), base, base);
					default: send_pixel(base, 8'($urandom), base);
				endcase
			end
		endcase
	endtask

	// extremes, gray, primaries, ties, band edges and rounding halves
	task automatic test_directed();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd10, 8'd10, 8'd200);
		send_pixel(8'd200, 8'd10, 8'd10);
		send_pixel(8'd10, 8'd200, 8'd10);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd100, 8'd105, 8'd100);
		send_pixel(8'd100, 8'd106, 8'd100);
		send_pixel(8'd100, 8'd119, 8'd100);
		send_pixel(8'd100, 8'd120, 8'd100);
		send_pixel(8'd100, 8'd159, 8'd100);
		send_pixel(8'd100, 8'd160, 8'd100);
		send_pixel(8'd50, 8'd50, 8'd159);
		send_pixel(8'd50, 8'd50, 8'd160);
		send_pixel(8'd254, 8'd1, 8'd128);
		send_pixel(8'd3, 8'd0, 8'd2);
	endtask

	task automatic test_random_traffic(input int count);
		src_idle = 1'b1;
		sink_idle = 1'b1;
		repeat (count) send_random_pixel();
	endtask

	// back-to-back pixels with no gaps and no stalls
	task automatic test_full_rate(input int count);
		src_idle = 1'b0;
		sink_idle = 1'b0;
		repeat (count) send_random_pixel();
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// output held off while input keeps offering until the pipeline fills
	task automatic test_output_hold(input int count);
		src_idle = 1'b0;
		hold_ticks = LONG_HOLD;
		repeat (count) send_random_pixel();
		src_idle = 1'b1;
		wait_drained();
	endtask

	// input pauses until every pending result has come out
	task automatic test_drain_pause(input int count);
		repeat (count) send_random_pixel();
		wait_drained();
		repeat (count) send_random_pixel();
		wait_drained();
	endtask

	initial begin
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(700);
		test_full_rate(200);
		test_output_hold(150);
		test_drain_pause(90);
		test_random_traffic(700);
		wait_drained();
		repeat (TAIL_TICKS) @(posedge clk);
		mismatches += expected_hmmd.size();
		$display("%0d pixels sent, %0d results checked, %0d mismatches", pixels_sent,
			results_checked, mismatches);
		$display("covered gray and tied pixels, all diff bands, full-rate and stalled flow");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> rgb_to_hmmd_bin_quantizer_top.f
src/rhbq_pkg.sv
src/rhbq_hue_div.sv
src/rgb_to_hmmd_bin_quantizer_top.sv
verif/tb.sv
